// ===== design/ils_pkg.sv =====
`timescale 1ns / 1ps
// ils_pkg: opcode and status codes and field widths for the indexed list store
// no dependencies; used by indexed_list_store
package ils_pkg;

    // field widths
    localparam int OPCODE_W   = 2;
    localparam int POSITION_W = 16;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_OUT_W = 7;

    typedef logic [OPCODE_W-1:0] opcode_t;
    typedef logic [STATUS_W-1:0] status_t;

    // request opcodes
    localparam opcode_t OP_READ   = 2'd0;
    localparam opcode_t OP_INSERT = 2'd1;
    localparam opcode_t OP_REMOVE = 2'd2;

    // result status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

// ===== design/ils_ram.sv =====
`timescale 1ns / 1ps
// ils_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module ils_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/indexed_list_store.sv =====
`timescale 1ns / 1ps
// indexed_list_store: position-addressed ordered store of signed 32-bit values
// depends on ils_pkg and ils_ram

// An ordered list of up to DEPTH values, held in one simple dual-port ram
// (one write, one registered read a cycle). Each transaction reads, inserts or
// removes at a position clamped into 0..count-1, and gives one result with the
// value, a status and the entry count afterwards. One request is handled at a
// time; s_ready is high only between requests, while a finished result may
// still wait on m_ready. Insert and remove move entries through the ram one
// at a time, each move a read followed by a write; refused, empty and
// unused-code requests go straight to the result. Ram contents are not cleared
// after reset; only written entries are ever read.
module indexed_list_store #(
    parameter int DEPTH = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ils_pkg::opcode_t                    s_opcode,
    input  logic signed [ils_pkg::POSITION_W-1:0] s_position,
    input  logic signed [ils_pkg::VALUE_W-1:0]  s_item_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [ils_pkg::VALUE_W-1:0]  m_read_value,
    output ils_pkg::status_t                    m_status,
    output logic [ils_pkg::COUNT_OUT_W-1:0]     m_entry_count
);
    import ils_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W + 1 > POSITION_W + 1) ? CNT_W + 1 : POSITION_W + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_RDCAP = 3'd2;
    localparam logic [2:0] S_SHRD  = 3'd3;
    localparam logic [2:0] S_SHWR  = 3'd4;
    localparam logic [2:0] S_INSWR = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]         state_reg, state_next;
    opcode_t            op_reg, op_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic               dir_reg, dir_next;
    logic [VALUE_W-1:0] val_reg, val_next;
    logic [VALUE_W-1:0] res_reg, res_next;
    status_t            status_reg, status_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic                   m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]     m_value_reg, m_value_next;
    status_t                m_status_reg, m_status_next;
    logic [COUNT_OUT_W-1:0] m_count_reg, m_count_next;

    logic                   accept;
    logic                   out_load;
    logic signed [CMP_W-1:0] pos_ext, cnt_ext, clamp_val;
    logic [ADDR_W-1:0]      pos_clamped;
    logic [CNT_W:0]         idx_plus2, pos_plus1, count_ext;
    logic [ADDR_W-1:0]      src_addr;
    logic [CNT_W+COUNT_OUT_W-1:0] cnt_wide;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [VALUE_W-1:0] ram_wdata, ram_rdata;

    ils_ram #(
        .WIDTH(VALUE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign out_load = (state_reg == S_DONE) && (!m_valid_reg || m_ready);

    // position clamp into 0..count-1
    always_comb begin
        pos_ext = {{(CMP_W - POSITION_W){s_position[POSITION_W-1]}}, s_position};
        cnt_ext = $signed({{(CMP_W - CNT_W){1'b0}}, count_reg});
        clamp_val = pos_ext;
        if (pos_ext >= cnt_ext) begin
            clamp_val = cnt_ext - CMP_W'(1);
        end
        if (clamp_val < 0) begin
            clamp_val = '0;
        end
        pos_clamped = clamp_val[ADDR_W-1:0];
    end

    // address arithmetic for the shift loop
    assign idx_plus2 = {{(CNT_W + 1 - ADDR_W){1'b0}}, idx_reg} + (CNT_W + 1)'(2);
    assign pos_plus1 = {{(CNT_W + 1 - ADDR_W){1'b0}}, pos_reg} + (CNT_W + 1)'(1);
    assign count_ext = {1'b0, count_reg};
    assign src_addr  = dir_reg ? (idx_reg - ADDR_W'(1)) : (idx_reg + ADDR_W'(1));

    // ram port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        ram_wdata = ram_rdata;
        ram_raddr = pos_reg;
        case (state_reg)
            S_SHRD: begin
                ram_raddr = src_addr;
            end
            S_SHWR: begin
                ram_we = 1'b1;
            end
            S_INSWR: begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = val_reg;
            end
            default: begin
                ram_raddr = pos_reg;
            end
        endcase
    end

    // sequencer
    always_comb begin
        state_next  = state_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        idx_next    = idx_reg;
        dir_next    = dir_reg;
        val_next    = val_reg;
        res_next    = res_reg;
        status_next = status_reg;
        count_next  = count_reg;
        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    op_next     = s_opcode;
                    pos_next    = pos_clamped;
                    val_next    = s_item_value;
                    res_next    = '0;
                    status_next = ST_OK;
                    idx_next    = count_reg[ADDR_W-1:0];
                    dir_next    = 1'b1;
                    state_next  = S_DONE;
                    if (s_opcode == OP_READ || s_opcode == OP_REMOVE) begin
                        if (count_reg == '0) begin
                            status_next = ST_EMPTY;
                        end else begin
                            state_next = S_RD;
                        end
                    end else if (s_opcode == OP_INSERT) begin
                        if (count_reg == CNT_W'(DEPTH)) begin
                            status_next = ST_FULL;
                        end else if (count_reg[ADDR_W-1:0] > pos_clamped) begin
                            state_next = S_SHRD;
                        end else begin
                            state_next = S_INSWR;
                        end
                    end
                end
            end
            S_RD: begin
                state_next = S_RDCAP;
            end
            S_RDCAP: begin
                res_next   = ram_rdata;
                idx_next   = pos_reg;
                dir_next   = 1'b0;
                state_next = S_DONE;
                if (op_reg == OP_REMOVE && pos_plus1 < count_ext) begin
                    state_next = S_SHRD;
                end
            end
            S_SHRD: begin
                state_next = S_SHWR;
            end
            S_SHWR: begin
                if (dir_reg) begin
                    idx_next   = idx_reg - ADDR_W'(1);
                    state_next = ((idx_reg - ADDR_W'(1)) > pos_reg) ? S_SHRD : S_INSWR;
                end else begin
                    idx_next   = idx_reg + ADDR_W'(1);
                    state_next = (idx_plus2 < count_ext) ? S_SHRD : S_DONE;
                end
            end
            S_INSWR: begin
                state_next = S_DONE;
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                    if (status_reg == ST_OK && op_reg == OP_INSERT) begin
                        count_next = count_reg + CNT_W'(1);
                    end else if (status_reg == ST_OK && op_reg == OP_REMOVE) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // output register
    assign cnt_wide = (CNT_W + COUNT_OUT_W)'(count_next);

    always_comb begin
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        if (out_load) begin
            m_valid_next  = 1'b1;
            m_value_next  = res_reg;
            m_status_next = status_reg;
            m_count_next  = cnt_wide[COUNT_OUT_W-1:0];
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        pos_reg      <= pos_next;
        idx_reg      <= idx_next;
        dir_reg      <= dir_next;
        val_reg      <= val_next;
        res_reg      <= res_next;
        status_reg   <= status_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = m_value_reg;
    assign m_status      = m_status_reg;
    assign m_entry_count = m_count_reg;

`ifndef SYNTHESIS
    // fill count never passes capacity
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("fill count above capacity");

    // the count only moves when a result is loaded
    assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> $past(out_load))
        else $error("fill count changed outside result load");

    // an empty report carries a zero value and a zero count
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_EMPTY) |-> (m_read_value == '0 && m_entry_count == '0))
        else $error("empty result with nonzero value or count");

    // a refused insert reports a full store
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == ST_FULL) |-> (m_entry_count == COUNT_OUT_W'(DEPTH)))
        else $error("full status with wrong count");

    // ram writes stay below the fill count plus one
    assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> ({{(CNT_W + 1 - ADDR_W){1'b0}}, ram_waddr} <= count_ext))
        else $error("ram write beyond list end");
`endif

endmodule

// ===== bench/tb_indexed_list_store.sv =====
`timescale 1ns / 1ps
// tb_indexed_list_store: self-checking bench for the indexed list store
// depends on ils_pkg and indexed_list_store; a directed table, then random fill/drain/mixed runs
module tb_indexed_list_store;
    import ils_pkg::*;

    localparam int LIST_DEPTH   = 64;
    localparam int DRAIN_CYCLES = 2 * LIST_DEPTH + 16;
    // code with no operation behind it, still legal on the port
    localparam opcode_t OP_UNUSED = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        status_t                   status;
        logic [COUNT_OUT_W-1:0]    count;
    } list_result_t;

    typedef struct packed {
        opcode_t                      op;
        logic signed [POSITION_W-1:0] pos;
        logic signed [VALUE_W-1:0]    val;
        logic                         typed;
        list_result_t                 want;
    } request_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    opcode_t s_opcode = OP_READ;
    logic signed [POSITION_W-1:0] s_position = '0;
    logic signed [VALUE_W-1:0] s_item_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [VALUE_W-1:0] m_read_value;
    status_t m_status;
    logic [COUNT_OUT_W-1:0] m_entry_count;

    // shadow copy of the list contents and fill level
    logic signed [VALUE_W-1:0] list_mem [LIST_DEPTH];
    int list_count = 0;

    list_result_t pending_results [$];
    request_row_t directed_rows [$];
    int fail_count = 0;

    // typed expectation of the transaction currently offered
    logic row_typed = 1'b0;
    list_result_t row_want = '0;
    logic sender_calm = 1'b0;
    logic receiver_calm = 1'b0;

    indexed_list_store #(
        .DEPTH(LIST_DEPTH)
    ) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_opcode     (s_opcode),
        .s_position   (s_position),
        .s_item_value (s_item_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_entry_count(m_entry_count)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // apply one request to the shadow list and return its result
    function automatic list_result_t list_apply(opcode_t op, logic signed [POSITION_W-1:0] pos,
                                                logic signed [VALUE_W-1:0] val);
        list_result_t res;
        int p;
        res = '0;
        res.status = ST_OK;
        p = int'(pos);
        if (p >= list_count) p = list_count - 1;
        if (p < 0) p = 0;
        case (op)
            OP_READ: begin
                if (list_count == 0) res.status = ST_EMPTY;
                else res.value = list_mem[p];
            end
            OP_INSERT: begin
                if (list_count >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = list_count; i > p; i--) list_mem[i] = list_mem[i-1];
                    list_mem[p] = val;
                    list_count++;
                end
            end
            OP_REMOVE: begin
                if (list_count == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    res.value = list_mem[p];
                    for (int i = p; i + 1 < list_count; i++) list_mem[i] = list_mem[i+1];
                    list_count--;
                end
            end
            default: ;
        endcase
        res.count = list_count[COUNT_OUT_W-1:0];
        return res;
    endfunction

    function automatic void add_row(opcode_t op, logic signed [POSITION_W-1:0] pos,
                                    logic signed [VALUE_W-1:0] val, logic typed,
                                    logic signed [VALUE_W-1:0] wval, status_t wst,
                                    logic [COUNT_OUT_W-1:0] wcnt);
        request_row_t row;
        row.op = op;
        row.pos = pos;
        row.val = val;
        row.typed = typed;
        row.want = '{value: wval, status: wst, count: wcnt};
        directed_rows.push_back(row);
    endfunction

    // mostly edges and in-range positions, some fully random
    function automatic logic signed [POSITION_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return -16'sd1;
            3: return 16'sd0;
            4, 5: return POSITION_W'($urandom);
            default: return POSITION_W'($urandom_range(0, list_count));
        endcase
    endfunction

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'sh80000000;
            1: return 32'sh7fffffff;
            2: return 32'sd0;
            3: return -32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // offer one transaction, called at a falling edge, returns at a falling edge
    task automatic send_request(opcode_t op, logic signed [POSITION_W-1:0] pos,
                                logic signed [VALUE_W-1:0] val, logic typed,
                                list_result_t want);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_opcode <= op;
        s_position <= pos;
        s_item_value <= val;
        row_typed = typed;
        row_want = want;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // predict on accepted requests, check accepted results
    always @(posedge aclk) begin
        list_result_t predicted;
        list_result_t wanted;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                predicted = list_apply(s_opcode, s_position, s_item_value);
                pending_results.push_back(row_typed ? row_want : predicted);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transaction with no request outstanding");
                    fail_count++;
                end else begin
                    wanted = pending_results.pop_front();
                    if (m_read_value !== wanted.value) begin
                        $error("read_value: expected %0d, got %0d", wanted.value, m_read_value);
                        fail_count++;
                    end
                    if (m_status !== wanted.status) begin
                        $error("status: expected %0d, got %0d", wanted.status, m_status);
                        fail_count++;
                    end
                    if (m_entry_count !== wanted.count) begin
                        $error("entry_count: expected %0d, got %0d", wanted.count,
                               m_entry_count);
                        fail_count++;
                    end
                end
            end
        end
    end

    // result side backpressure
    initial begin
        int stall;
        int taken;
        taken = 0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (taken % 40 == 0) receiver_calm = ($urandom_range(0, 3) == 0);
            stall = receiver_calm ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
            @(negedge aclk);
        end
    end

    // stimulus and end of run
    initial begin
        opcode_t op;
        int pick;
        // empty store, unused code, edges of position and value
        add_row(OP_READ,    16'sd0,      32'sd0,          1'b1, 32'sd0, ST_EMPTY, 7'd0);
        add_row(OP_REMOVE,  16'sh7fff,   32'sd0,          1'b1, 32'sd0, ST_EMPTY, 7'd0);
        add_row(OP_UNUSED,  -16'sd1,     -32'sd1,         1'b1, 32'sd0, ST_OK,    7'd0);
        add_row(OP_INSERT,  16'sh8000,   32'sh7fffffff,   1'b1, 32'sd0, ST_OK,    7'd1);
        add_row(OP_READ,    16'sh7fff,   32'sd0,          1'b1, 32'sh7fffffff, ST_OK, 7'd1);
        // insert past the end lands before the last entry
        add_row(OP_INSERT,  16'sh7fff,   32'sh80000000,   1'b1, 32'sd0, ST_OK,    7'd2);
        add_row(OP_READ,    16'sd0,      32'sd0,          1'b1, 32'sh80000000, ST_OK, 7'd2);
        add_row(OP_READ,    16'sh8000,   32'sd0,          1'b1, 32'sh80000000, ST_OK, 7'd2);
        add_row(OP_READ,    16'sd1,      32'sd0,          1'b1, 32'sh7fffffff, ST_OK, 7'd2);
        add_row(OP_INSERT,  16'sd1,      32'sd0,          1'b0, '0, ST_OK, '0);
        add_row(OP_INSERT,  16'sd0,      32'sd1,          1'b0, '0, ST_OK, '0);
        add_row(OP_INSERT,  -16'sd1,     -32'sd1,         1'b0, '0, ST_OK, '0);
        add_row(OP_INSERT,  16'sd2,      32'sh5a5a5a5a,   1'b0, '0, ST_OK, '0);
        add_row(OP_UNUSED,  16'sd0,      32'sh12345678,   1'b0, '0, ST_OK, '0);
        add_row(OP_READ,    16'sd2,      32'sd0,          1'b0, '0, ST_OK, '0);
        add_row(OP_READ,    16'sd5,      32'sd0,          1'b0, '0, ST_OK, '0);
        add_row(OP_READ,    16'sd100,    32'sd0,          1'b0, '0, ST_OK, '0);
        // drain from the head, tail and middle down to empty
        add_row(OP_REMOVE,  16'sd0,      32'sd0,          1'b0, '0, ST_OK, '0);
        add_row(OP_REMOVE,  16'sh7fff,   32'sd0,          1'b0, '0, ST_OK, '0);
        add_row(OP_REMOVE,  16'sd1,      32'sd0,          1'b0, '0, ST_OK, '0);
        add_row(OP_REMOVE,  16'sh8000,   32'sd0,          1'b0, '0, ST_OK, '0);
        add_row(OP_REMOVE,  16'sh7fff,   32'sd0,          1'b0, '0, ST_OK, '0);
        add_row(OP_REMOVE,  16'sd0,      -32'sd1,         1'b0, '0, ST_OK, '0);
        add_row(OP_REMOVE,  -16'sd1,     32'sd0,          1'b1, 32'sd0, ST_EMPTY, 7'd0);
        add_row(OP_READ,    -16'sd1,     32'sd0,          1'b1, 32'sd0, ST_EMPTY, 7'd0);

        aresetn = 1'b0;
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_rows[i])
            send_request(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].val,
                         directed_rows[i].typed, directed_rows[i].want);

        // fill to full, drain to empty, then mixed traffic, twice over
        for (int seg = 0; seg < 6; seg++) begin
            for (int k = 0; k < 120; k++) begin
                if (k % 40 == 0) sender_calm = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 19);
                case (seg % 3)
                    0: op = (pick < 18) ? OP_INSERT : ((pick == 18) ? OP_READ : OP_REMOVE);
                    1: op = (pick < 18) ? OP_REMOVE : ((pick == 18) ? OP_READ : OP_INSERT);
                    default: begin
                        if (pick == 0) op = OP_UNUSED;
                        else if (pick < 8) op = OP_READ;
                        else if (pick < 14) op = OP_INSERT;
                        else op = OP_REMOVE;
                    end
                endcase
                send_request(op, pick_position(), pick_value(), 1'b0, '0);
            end
        end
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
